@@ design/sliding_window_rate_alarm_core_assert.svh @@
// Assertion macros; the clock is clk and the reset is rst_n at the point of use.
`ifndef SLIDING_WINDOW_RATE_ALARM_CORE_ASSERT_SVH
`define SLIDING_WINDOW_RATE_ALARM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SWRA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SWRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWRA_ASSERT_IMPL(label, ante, cons, msg)
`define SWRA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ design/swra_pkg.sv @@
`default_nettype none
package swra_pkg;
  localparam int TIME_W = 40;
  localparam int CNT_W = 24;
  localparam int SPAN = 64;
  localparam int SLOT_W = $clog2(SPAN);
  localparam int SUM_W = 32;
  localparam int THR_W = 24;
  localparam int WSZ_W = 6;
  localparam int WD_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int MAX_RES = 64;
  localparam int NRES_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_DELAY = 2'd2;

  localparam logic [THR_W-1:0] THR_RESET = 24'd10;
  localparam logic [WSZ_W-1:0] WSZ_RESET = 6'd32;
  localparam logic [WD_W-1:0] WD_RESET = 4'd2;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic re;
    logic we;
    logic [SLOT_W-1:0] addr;
    logic [CNT_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic start;
    logic [SUM_W-1:0] dividend;
    logic [WSZ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [SUM_W-1:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

@@ design/swra_if.sv @@
`default_nettype none
interface swra_evt_if;
  logic valid;
  logic ready;
  logic [swra_pkg::TIME_W-1:0] event_time;
  modport source (output valid, output event_time, input ready);
  modport sink (input valid, input event_time, output ready);
endinterface

interface swra_res_if;
  logic valid;
  logic ready;
  logic alert_on;
  logic [swra_pkg::SUM_W-1:0] average_hits;
  logic [swra_pkg::TIME_W-1:0] window_end_time;
  logic rejected;
  logic last_result;
  modport source (output valid, output alert_on, output average_hits,
                  output window_end_time, output rejected, output last_result,
                  input ready);
  modport sink (input valid, input alert_on, input average_hits,
                input window_end_time, input rejected, input last_result,
                output ready);
endinterface

interface swra_cfg_if;
  logic valid;
  logic ready;
  logic [swra_pkg::CFG_IDX_W-1:0] index;
  logic [swra_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ design/swra_cnt_mem.sv @@
`default_nettype none
module swra_cnt_mem (
  input  wire logic                  clk,
  input  wire swra_pkg::mem_req_t    req,
  output logic [swra_pkg::CNT_W-1:0] rdata
);
  import swra_pkg::*;

  logic [CNT_W-1:0] mem [SPAN];
  logic [CNT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

@@ design/swra_div.sv @@
`default_nettype none
module swra_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire swra_pkg::div_req_t req,
  output swra_pkg::div_rsp_t      rsp
);
  import swra_pkg::*;

  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] quot_r, quot_nxt;
  logic [WSZ_W-1:0] rem_r, rem_nxt;
  logic [WSZ_W-1:0] dvs_r, dvs_nxt;
  logic [WSZ_W:0] rem_sh;
  logic ge;

  always_comb begin
    rem_sh = {rem_r, quot_r[SUM_W-1]};
    ge = rem_sh >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    quot_nxt = quot_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 5'd31;
      quot_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
    end else if (busy_r) begin
      quot_nxt = {quot_r[SUM_W-2:0], ge};
      rem_nxt = ge ? WSZ_W'(rem_sh - {1'b0, dvs_r}) : WSZ_W'(rem_sh);
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quot_r <= quot_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
endmodule
`default_nettype wire

@@ design/sliding_window_rate_alarm_core.sv @@
`default_nettype none
// Sliding-window rate alarm. After reset the block sweeps its 64-entry count
// memory to zero and takes no event meanwhile; configuration writes are
// taken at any time. An event of time 0 is taken and dropped while the input
// stays ready. After any other event transfer the input stays not ready while
// the event is handled, whether it is a dropped late event, a rejected one or
// a counted hit, and while the slots added when the stored span grows (1 to
// 63) are cleared. Each window evaluation waits on the 32-step shared
// divider; the first window also sums its seconds one by one through the
// single memory port. A change of the alert state hands the result over
// through the emit state, and stalls while the output register and the
// pending result are both full.
`include "sliding_window_rate_alarm_core_assert.svh"
module sliding_window_rate_alarm_core (
  input wire logic  clk,
  input wire logic  rst_n,
  swra_evt_if.sink  in_if,
  swra_res_if.source out_if,
  swra_cfg_if.sink  cfg_if
);
  import swra_pkg::*;

  typedef enum logic [17:0] {
    ST_CLR  = 18'h00001,
    ST_IDLE = 18'h00002,
    ST_CLS  = 18'h00004,
    ST_CLRR = 18'h00008,
    ST_HRD  = 18'h00010,
    ST_HWR  = 18'h00020,
    ST_WST  = 18'h00040,
    ST_WCHK = 18'h00080,
    ST_FRD  = 18'h00100,
    ST_FACC = 18'h00200,
    ST_LRD  = 18'h00400,
    ST_LACC = 18'h00800,
    ST_EACC = 18'h01000,
    ST_DIVS = 18'h02000,
    ST_DIVW = 18'h04000,
    ST_WADV = 18'h08000,
    ST_EMIT = 18'h10000,
    ST_FIN  = 18'h20000
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [TIME_W-1:0] t_r, t_nxt, newest_r, newest_nxt, oldest_r, oldest_nxt;
  logic [TIME_W-1:0] ws_r, ws_nxt;
  logic first_r, first_nxt, alert_r, alert_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic [WSZ_W-1:0] wsz_r, wsz_nxt;
  logic [WD_W-1:0] wd_r, wd_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt, left_r, left_nxt;
  logic [NRES_W-1:0] n_r, n_nxt;
  logic nr_alert_r, nr_alert_nxt, nr_rej_r, nr_rej_nxt;
  logic [SUM_W-1:0] nr_avg_r, nr_avg_nxt;
  logic [TIME_W-1:0] nr_end_r, nr_end_nxt;
  logic pd_v_r, pd_v_nxt, pd_alert_r, pd_alert_nxt, pd_rej_r, pd_rej_nxt;
  logic [SUM_W-1:0] pd_avg_r, pd_avg_nxt;
  logic [TIME_W-1:0] pd_end_r, pd_end_nxt;
  logic ov_r, ov_nxt, o_alert_r, o_alert_nxt, o_rej_r, o_rej_nxt;
  logic o_last_r, o_last_nxt;
  logic [SUM_W-1:0] o_avg_r, o_avg_nxt;
  logic [TIME_W-1:0] o_end_r, o_end_nxt;

  mem_req_t mreq;
  logic [CNT_W-1:0] rdata;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [WSZ_W-1:0] wsz_eff;
  logic [TIME_W-1:0] win_end, t_span, t_back;
  logic [TIME_W+1:0] win_lim;
  logic [SUM_W:0] sum_add;
  logic out_free;

  swra_cnt_mem u_mem (.clk(clk), .req(mreq), .rdata(rdata));
  swra_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_if.ready = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = ov_r;
  assign out_if.alert_on = o_alert_r;
  assign out_if.average_hits = o_avg_r;
  assign out_if.window_end_time = o_end_r;
  assign out_if.rejected = o_rej_r;
  assign out_if.last_result = o_last_r;

  always_comb begin
    wsz_eff = (wsz_r == '0) ? WSZ_W'(1) : wsz_r;
    win_end = ws_r + TIME_W'(wsz_eff) - TIME_W'(1);
    win_lim = {2'b00, ws_r} + (TIME_W+2)'(wsz_eff) - (TIME_W+2)'(1)
              + (TIME_W+2)'(wd_r);
    t_span = t_r - oldest_r;
    t_back = newest_r - t_r;
    sum_add = {1'b0, sum_r} + (SUM_W+1)'(rdata);
    out_free = !ov_r || out_if.ready;

    state_nxt = state_r;
    ret_nxt = ret_r;
    t_nxt = t_r;
    newest_nxt = newest_r;
    oldest_nxt = oldest_r;
    ws_nxt = ws_r;
    first_nxt = first_r;
    alert_nxt = alert_r;
    sum_nxt = sum_r;
    thr_nxt = thr_r;
    wsz_nxt = wsz_r;
    wd_nxt = wd_r;
    ptr_nxt = ptr_r;
    left_nxt = left_r;
    n_nxt = n_r;
    nr_alert_nxt = nr_alert_r;
    nr_rej_nxt = nr_rej_r;
    nr_avg_nxt = nr_avg_r;
    nr_end_nxt = nr_end_r;
    pd_v_nxt = pd_v_r;
    pd_alert_nxt = pd_alert_r;
    pd_rej_nxt = pd_rej_r;
    pd_avg_nxt = pd_avg_r;
    pd_end_nxt = pd_end_r;
    ov_nxt = ov_r && !out_if.ready;
    o_alert_nxt = o_alert_r;
    o_rej_nxt = o_rej_r;
    o_last_nxt = o_last_r;
    o_avg_nxt = o_avg_r;
    o_end_nxt = o_end_r;
    mreq = '0;
    dreq = '0;
    dreq.dividend = sum_r;
    dreq.divisor = wsz_eff;

    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_THRESHOLD:   thr_nxt = cfg_if.data;
        CFG_WINDOW_SIZE: wsz_nxt = cfg_if.data[WSZ_W-1:0];
        CFG_WAIT_DELAY:  wd_nxt = cfg_if.data[WD_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_CLR: begin
        mreq.we = 1'b1;
        mreq.addr = ptr_r;
        ptr_nxt = ptr_r + SLOT_W'(1);
        if (ptr_r == {SLOT_W{1'b1}}) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        n_nxt = '0;
        if (in_if.valid) begin
          t_nxt = in_if.event_time;
          if (in_if.event_time != '0) state_nxt = ST_CLS;
        end
      end
      ST_CLS: begin
        nr_alert_nxt = alert_r;
        nr_avg_nxt = '0;
        nr_end_nxt = '0;
        nr_rej_nxt = 1'b1;
        ret_nxt = ST_WST;
        priority if (newest_r == '0) begin
          newest_nxt = t_r;
          oldest_nxt = t_r;
          ptr_nxt = t_r[SLOT_W-1:0];
          left_nxt = '0;
          state_nxt = ST_CLRR;
        end else if (t_r > newest_r) begin
          if (t_span >= TIME_W'(SPAN)) begin
            state_nxt = ST_EMIT;
          end else begin
            ptr_nxt = SLOT_W'(newest_r + TIME_W'(1));
            left_nxt = SLOT_W'(t_r - newest_r - TIME_W'(1));
            newest_nxt = t_r;
            state_nxt = ST_CLRR;
          end
        end else if (t_r >= oldest_r) begin
          state_nxt = ST_HRD;
        end else if (ws_r != '0 && ({1'b0, t_r} + (TIME_W+1)'(1)) < {1'b0, ws_r}) begin
          state_nxt = ST_WST;
        end else if (t_back >= TIME_W'(SPAN)) begin
          state_nxt = ST_EMIT;
        end else begin
          ptr_nxt = t_r[SLOT_W-1:0];
          left_nxt = SLOT_W'(oldest_r - t_r - TIME_W'(1));
          oldest_nxt = t_r;
          state_nxt = ST_CLRR;
        end
      end
      ST_CLRR: begin
        mreq.we = 1'b1;
        mreq.addr = ptr_r;
        ptr_nxt = ptr_r + SLOT_W'(1);
        left_nxt = left_r - SLOT_W'(1);
        if (left_r == '0) state_nxt = ST_HRD;
      end
      ST_HRD: begin
        mreq.re = 1'b1;
        mreq.addr = t_r[SLOT_W-1:0];
        state_nxt = ST_HWR;
      end
      ST_HWR: begin
        mreq.we = 1'b1;
        mreq.addr = t_r[SLOT_W-1:0];
        mreq.wdata = (rdata == CNT_MAX) ? rdata : rdata + CNT_W'(1);
        state_nxt = ST_WST;
      end
      ST_WST: begin
        if (ws_r == '0 && (newest_r - oldest_r) >= TIME_W'(wd_r)) ws_nxt = oldest_r;
        state_nxt = ST_WCHK;
      end
      ST_WCHK: begin
        if (ws_r != '0 && {2'b00, newest_r} >= win_lim) begin
          if (!first_r) begin
            sum_nxt = '0;
            ptr_nxt = ws_r[SLOT_W-1:0];
            left_nxt = wsz_eff - WSZ_W'(1);
            state_nxt = ST_FRD;
          end else begin
            state_nxt = ST_LRD;
          end
        end else begin
          if (ws_r != '0 && (ws_r - TIME_W'(1)) > oldest_r) oldest_nxt = ws_r - TIME_W'(1);
          state_nxt = ST_FIN;
        end
      end
      ST_FRD: begin
        mreq.re = 1'b1;
        mreq.addr = ptr_r;
        state_nxt = ST_FACC;
      end
      ST_FACC: begin
        sum_nxt = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        ptr_nxt = ptr_r + SLOT_W'(1);
        left_nxt = left_r - SLOT_W'(1);
        if (left_r == '0) begin
          first_nxt = 1'b1;
          state_nxt = ST_DIVS;
        end else begin
          state_nxt = ST_FRD;
        end
      end
      ST_LRD: begin
        mreq.re = 1'b1;
        mreq.addr = SLOT_W'(ws_r - TIME_W'(1));
        state_nxt = ST_LACC;
      end
      ST_LACC: begin
        sum_nxt = (sum_r > SUM_W'(rdata)) ? sum_r - SUM_W'(rdata) : '0;
        mreq.re = 1'b1;
        mreq.addr = win_end[SLOT_W-1:0];
        state_nxt = ST_EACC;
      end
      ST_EACC: begin
        sum_nxt = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        dreq.start = 1'b1;
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (drsp.done) begin
          if ((drsp.quot >= SUM_W'(thr_r)) != alert_r) begin
            alert_nxt = !alert_r;
            nr_alert_nxt = !alert_r;
            nr_avg_nxt = drsp.quot;
            nr_end_nxt = win_end;
            nr_rej_nxt = 1'b0;
            ret_nxt = ST_WADV;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_WADV;
          end
        end
      end
      ST_WADV: begin
        ws_nxt = ws_r + TIME_W'(1);
        state_nxt = ST_WCHK;
      end
      ST_EMIT: begin
        if (n_r >= NRES_W'(MAX_RES)) begin
          state_nxt = ret_r;
        end else if (!pd_v_r || out_free) begin
          if (pd_v_r) begin
            ov_nxt = 1'b1;
            o_alert_nxt = pd_alert_r;
            o_avg_nxt = pd_avg_r;
            o_end_nxt = pd_end_r;
            o_rej_nxt = pd_rej_r;
            o_last_nxt = 1'b0;
          end
          pd_v_nxt = 1'b1;
          pd_alert_nxt = nr_alert_r;
          pd_avg_nxt = nr_avg_r;
          pd_end_nxt = nr_end_r;
          pd_rej_nxt = nr_rej_r;
          n_nxt = n_r + NRES_W'(1);
          state_nxt = ret_r;
        end
      end
      ST_FIN: begin
        if (!pd_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          ov_nxt = 1'b1;
          o_alert_nxt = pd_alert_r;
          o_avg_nxt = pd_avg_r;
          o_end_nxt = pd_end_r;
          o_rej_nxt = pd_rej_r;
          o_last_nxt = 1'b1;
          pd_v_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      ret_r <= ST_WST;
      newest_r <= '0;
      oldest_r <= '0;
      ws_r <= '0;
      first_r <= 1'b0;
      alert_r <= 1'b0;
      sum_r <= '0;
      thr_r <= THR_RESET;
      wsz_r <= WSZ_RESET;
      wd_r <= WD_RESET;
      ptr_r <= '0;
      n_r <= '0;
      pd_v_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      newest_r <= newest_nxt;
      oldest_r <= oldest_nxt;
      ws_r <= ws_nxt;
      first_r <= first_nxt;
      alert_r <= alert_nxt;
      sum_r <= sum_nxt;
      thr_r <= thr_nxt;
      wsz_r <= wsz_nxt;
      wd_r <= wd_nxt;
      ptr_r <= ptr_nxt;
      n_r <= n_nxt;
      pd_v_r <= pd_v_nxt;
      ov_r <= ov_nxt;
    end
    t_r <= t_nxt;
    left_r <= left_nxt;
    nr_alert_r <= nr_alert_nxt;
    nr_rej_r <= nr_rej_nxt;
    nr_avg_r <= nr_avg_nxt;
    nr_end_r <= nr_end_nxt;
    pd_alert_r <= pd_alert_nxt;
    pd_rej_r <= pd_rej_nxt;
    pd_avg_r <= pd_avg_nxt;
    pd_end_r <= pd_end_nxt;
    o_alert_r <= o_alert_nxt;
    o_rej_r <= o_rej_nxt;
    o_last_r <= o_last_nxt;
    o_avg_r <= o_avg_nxt;
    o_end_r <= o_end_nxt;
  end

  `SWRA_ASSERT_IMPL(a_idle_flushed, state_r == ST_IDLE, !pd_v_r, "pending result left at idle")
  `SWRA_ASSERT_IMPL(a_res_cap, 1'b1, n_r <= NRES_W'(MAX_RES), "result count over cap")
  `SWRA_ASSERT_IMPL(a_div_done, drsp.done, state_r == ST_DIVW, "divider done outside wait")
  `SWRA_ASSERT_IMPL(a_ws_set, first_r, ws_r != '0, "first window done without start")
endmodule
`default_nettype wire
